/* hdl/npts_pkg.sv */
// Shared types, constants and codes for the nearest-point top-K selector.
package npts_pkg;

   // Map store geometry
   localparam int MAP_DEPTH     = 1024;
   localparam int MAP_ADDR_BITS = $clog2(MAP_DEPTH);
   localparam int MAP_CNT_BITS  = $clog2(MAP_DEPTH + 1);

   // Sorted candidate list
   localparam int K_MAX       = 64;
   localparam int K_CNT_BITS  = $clog2(K_MAX + 1);

   // Arithmetic widths
   localparam int COORD_BITS = 24;
   localparam int SQ_BITS    = 2 * COORD_BITS;
   localparam int DIST_BITS  = SQ_BITS + 1;
   localparam int BEST_BITS  = DIST_BITS + 1;
   localparam int POINT_BITS = 2 * COORD_BITS;

   // Configuration port
   localparam int CFG_BITS      = 11;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [CSR_ADDR_BITS-3:0] REG_POINTS_IN_USE = '0;

   // Request codes
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic                         req_type;
      logic [MAP_ADDR_BITS-1:0]     point_index;
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
   } req_beat_type;

   typedef struct packed {
      logic [MAP_ADDR_BITS-1:0] candidate_index;
      logic [DIST_BITS-1:0]     squared_distance;
      logic                     short_list;
      logic                     last_result;
   } rsp_beat_type;

   // Controller to datapath
   typedef struct packed {
      logic                     wr_point;
      logic                     load_query;
      logic                     clear_list;
      logic                     rd_en;
      logic [MAP_ADDR_BITS-1:0] rd_addr;
      logic                     pop;
      logic                     pop_last;
      logic                     short_list;
   } npts_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic pipe_busy;
      logic out_free;
   } npts_status_type;

endpackage

/* hdl/npts_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module npts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/npts_ctrl.sv */
// Controller: request decode, map scan sequencing and result emission.
module npts_ctrl import npts_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_kind,
   output logic                req_ready,
   input  logic [CFG_BITS-1:0] points_in_use,
   input  npts_status_type     status,
   output npts_cmd_type        cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [MAP_CNT_BITS-1:0] addr_ff, addr_in;
   logic [MAP_CNT_BITS-1:0] n_ff, n_in;
   logic [K_CNT_BITS-1:0]   k_ff, k_in;
   logic [K_CNT_BITS-1:0]   remain_ff, remain_in;
   logic                    short_ff, short_in;

   logic [MAP_CNT_BITS-1:0] n_sat;
   logic                    accept;

   // Saturate the map size to the store depth
   always_comb begin
      if (MAP_CNT_BITS'(points_in_use) > MAP_CNT_BITS'(MAP_DEPTH)) begin
         n_sat = MAP_CNT_BITS'(MAP_DEPTH);
      end else begin
         n_sat = MAP_CNT_BITS'(points_in_use);
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      addr_in   = addr_ff;
      n_in      = n_ff;
      k_in      = k_ff;
      remain_in = remain_ff;
      short_in  = short_ff;

      cmd            = '0;
      cmd.rd_addr    = addr_ff[MAP_ADDR_BITS-1:0];
      cmd.short_list = short_ff;
      cmd.pop_last   = (remain_ff == K_CNT_BITS'(1));

      case (state_ff)
         ST_IDLE: begin
            if (accept && req_kind == REQ_LOAD) begin
               cmd.wr_point = 1'b1;
            end
            if (accept && req_kind == REQ_QUERY) begin
               cmd.load_query = 1'b1;
               cmd.clear_list = 1'b1;
               n_in           = n_sat;
               addr_in        = '0;
               short_in       = (n_sat < MAP_CNT_BITS'(K_MAX));
               if (n_sat < MAP_CNT_BITS'(K_MAX)) begin
                  k_in = n_sat[K_CNT_BITS-1:0];
               end else begin
                  k_in = K_CNT_BITS'(K_MAX);
               end
               // Empty map: nothing to search, nothing to emit
               if (n_sat != '0) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.rd_en = 1'b1;
            addr_in   = addr_ff + MAP_CNT_BITS'(1);
            if (addr_ff == n_ff - MAP_CNT_BITS'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // Wait for the last distance to settle into the list
            if (!status.pipe_busy) begin
               remain_in = k_ff;
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.pop   = 1'b1;
               remain_in = remain_ff - K_CNT_BITS'(1);
               if (remain_ff == K_CNT_BITS'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      addr_ff   <= addr_in;
      n_ff      <= n_in;
      k_ff      <= k_in;
      remain_ff <= remain_in;
      short_ff  <= short_in;
   end

endmodule

/* hdl/npts_dpath.sv */
// Datapath: point store, distance pipeline, sorted candidate list, result register.
module npts_dpath import npts_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  req_beat_type    req_data,
   input  npts_cmd_type    cmd,
   output npts_status_type status,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_beat_type    rsp_data
);

   localparam logic [BEST_BITS-1:0] BEST_EMPTY = '1;

   // Query point
   logic signed [COORD_BITS-1:0] qx_ff, qy_ff;

   // Pipeline valids and indices
   logic                     v1_ff, v2_ff, v3_ff, v4_ff;
   logic [MAP_ADDR_BITS-1:0] idx1_ff, idx2_ff, idx3_ff, idx4_ff;

   logic [POINT_BITS-1:0]        point_rd;
   logic signed [COORD_BITS-1:0] map_x, map_y;
   logic signed [COORD_BITS:0]   diff_x, diff_y;
   logic [COORD_BITS-1:0]        dx_in, dy_in, dx_ff, dy_ff;
   logic [SQ_BITS-1:0]           sqx_ff, sqy_ff;
   logic [DIST_BITS-1:0]         dist_ff;

   // Sorted list, nearest at entry 0
   logic [BEST_BITS-1:0]     best_dist_ff [K_MAX];
   logic [BEST_BITS-1:0]     best_dist_in [K_MAX];
   logic [MAP_ADDR_BITS-1:0] best_idx_ff  [K_MAX];
   logic [MAP_ADDR_BITS-1:0] best_idx_in  [K_MAX];
   logic [K_MAX-1:0]         closer;

   logic         rsp_valid_ff;
   rsp_beat_type rsp_data_ff;

   npts_ram #(
      .WIDTH (POINT_BITS),
      .DEPTH (MAP_DEPTH)
   ) u_point_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_point),
      .wr_addr (req_data.point_index),
      .wr_data ({req_data.point_x, req_data.point_y}),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (point_rd)
   );

   // Capture the query point
   always_ff @(posedge clock) begin
      if (cmd.load_query) begin
         qx_ff <= req_data.point_x;
         qy_ff <= req_data.point_y;
      end
   end

   // Absolute coordinate differences
   assign map_x  = point_rd[POINT_BITS-1:COORD_BITS];
   assign map_y  = point_rd[COORD_BITS-1:0];
   assign diff_x = {map_x[COORD_BITS-1], map_x} - {qx_ff[COORD_BITS-1], qx_ff};
   assign diff_y = {map_y[COORD_BITS-1], map_y} - {qy_ff[COORD_BITS-1], qy_ff};

   always_comb begin
      if (diff_x[COORD_BITS]) begin
         dx_in = COORD_BITS'(-diff_x);
      end else begin
         dx_in = diff_x[COORD_BITS-1:0];
      end
      if (diff_y[COORD_BITS]) begin
         dy_in = COORD_BITS'(-diff_y);
      end else begin
         dy_in = diff_y[COORD_BITS-1:0];
      end
   end

   // Advance the distance pipeline: read, difference, square, sum
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.rd_en;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      idx1_ff <= cmd.rd_addr;
      idx2_ff <= idx1_ff;
      idx3_ff <= idx2_ff;
      idx4_ff <= idx3_ff;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      sqx_ff  <= dx_ff * dx_ff;
      sqy_ff  <= dy_ff * dy_ff;
      dist_ff <= DIST_BITS'(sqx_ff) + DIST_BITS'(sqy_ff);
   end

   assign status.pipe_busy = v1_ff || v2_ff || v3_ff || v4_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   // Strictly closer than each entry: equal distances keep the lower index first
   always_comb begin
      for (int i = 0; i < K_MAX; i++) begin
         closer[i] = ({1'b0, dist_ff} < best_dist_ff[i]);
      end
   end

   // Clear, insert with shift down, or pop with shift up
   always_comb begin
      for (int i = 0; i < K_MAX; i++) begin
         best_dist_in[i] = best_dist_ff[i];
         best_idx_in[i]  = best_idx_ff[i];
      end
      if (cmd.clear_list) begin
         for (int i = 0; i < K_MAX; i++) begin
            best_dist_in[i] = BEST_EMPTY;
            best_idx_in[i]  = '0;
         end
      end else if (v4_ff) begin
         if (closer[0]) begin
            best_dist_in[0] = {1'b0, dist_ff};
            best_idx_in[0]  = idx4_ff;
         end
         for (int i = 1; i < K_MAX; i++) begin
            if (closer[i - 1]) begin
               best_dist_in[i] = best_dist_ff[i - 1];
               best_idx_in[i]  = best_idx_ff[i - 1];
            end else if (closer[i]) begin
               best_dist_in[i] = {1'b0, dist_ff};
               best_idx_in[i]  = idx4_ff;
            end
         end
      end else if (cmd.pop) begin
         for (int i = 0; i < K_MAX - 1; i++) begin
            best_dist_in[i] = best_dist_ff[i + 1];
            best_idx_in[i]  = best_idx_ff[i + 1];
         end
         best_dist_in[K_MAX - 1] = BEST_EMPTY;
         best_idx_in[K_MAX - 1]  = '0;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < K_MAX; i++) begin
         best_dist_ff[i] <= best_dist_in[i];
         best_idx_ff[i]  <= best_idx_in[i];
      end
   end

   // Result register: load from the list head, drop when the beat is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.pop) begin
         rsp_data_ff.candidate_index  <= best_idx_ff[0];
         rsp_data_ff.squared_distance <= best_dist_ff[0][DIST_BITS-1:0];
         rsp_data_ff.short_list       <= cmd.short_list;
         rsp_data_ff.last_result      <= cmd.pop_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hdl/nearest_point_top_k_select.sv */
// Top level of the nearest-point top-K selector: register port and unit wiring.
//
// Load beats write one 2-D point into a 1024-entry point memory and are accepted
// back to back. A query beat scans points 0 to points_in_use-1 (saturated at
// 1024) through a read, difference, square and sum pipeline, one point per
// cycle, inserting each squared distance into a 64-entry sorted register list;
// it then emits min(64, map size) result beats, nearest first, one per cycle
// while the result side keeps up. A query holds the request side through its
// scan, drain and emission, with the scan paced by the single read port of the
// point memory. An empty map gives no result beats. Equal distances are
// reported in ascending point index order. points_in_use sits at byte address
// 0 of the register port and resets to zero.
module nearest_point_top_k_select import npts_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_beat_type             req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_beat_type             rsp_data,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   logic [CFG_BITS-1:0] points_in_use_ff;
   logic                csr_sel_points;
   npts_cmd_type        cmd;
   npts_status_type     status;

   // Register decode on the word address
   assign csr_sel_points = (csr_paddr[CSR_ADDR_BITS-1:2] == REG_POINTS_IN_USE);
   assign csr_pready     = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         points_in_use_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_sel_points) begin
         points_in_use_ff <= csr_pwdata[CFG_BITS-1:0];
      end
   end

   always_comb begin
      if (csr_sel_points) begin
         csr_prdata = CSR_DATA_BITS'(points_in_use_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   npts_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_kind      (req_data.req_type),
      .req_ready     (req_ready),
      .points_in_use (points_in_use_ff),
      .status        (status),
      .cmd           (cmd)
   );

   npts_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* sim/tb_nearest_point_top_k_select.sv */
// Self-checking testbench for the nearest-point top-K selector.
`timescale 1ns / 1ps

module tb_nearest_point_top_k_select import npts_pkg::*; ();

   localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic [CSR_ADDR_BITS-1:0] MAP_SIZE_ADDR = {REG_POINTS_IN_USE, 2'b00};
   localparam int SETTLE_CYCLES = 32;
   localparam int RANDOM_BEATS_PER_MODE = 135;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   req_beat_type             req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   rsp_beat_type             rsp_data;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   // Predictor state: point store, map size register, written slots
   logic signed [COORD_BITS-1:0] map_x [MAP_DEPTH];
   logic signed [COORD_BITS-1:0] map_y [MAP_DEPTH];
   bit                           slot_loaded [MAP_DEPTH];
   int                           map_size_reg = 0;

   rsp_beat_type pending_candidates[$];

   int req_gap_pct = 0;
   int rsp_stall_pct = 0;
   int error_count = 0;
   int items_sent = 0;
   int queries_sent = 0;
   int beats_checked = 0;

   nearest_point_top_k_select u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Rank the searched points by squared distance to the query, ties by lower slot
   function automatic void rank_nearest(logic signed [COORD_BITS-1:0] qx,
                                        logic signed [COORD_BITS-1:0] qy);
      longint       best_dist [K_MAX];
      int           best_slot [K_MAX];
      int           n;
      int           k;
      int           found;
      int           pos;
      longint       dx;
      longint       dy;
      longint       sq_dist;
      rsp_beat_type beat;
      n = (map_size_reg > MAP_DEPTH) ? MAP_DEPTH : map_size_reg;
      k = (n < K_MAX) ? n : K_MAX;
      found = 0;
      for (int i = 0; i < n; i++) begin
         dx = longint'(map_x[i]) - longint'(qx);
         dy = longint'(map_y[i]) - longint'(qy);
         sq_dist = dx * dx + dy * dy;
         if (found == k && sq_dist >= best_dist[k-1])
            continue;
         pos = (found < k) ? found : k - 1;
         while (pos > 0 && sq_dist < best_dist[pos-1]) begin
            best_dist[pos] = best_dist[pos-1];
            best_slot[pos] = best_slot[pos-1];
            pos--;
         end
         best_dist[pos] = sq_dist;
         best_slot[pos] = i;
         if (found < k)
            found++;
      end
      for (int j = 0; j < found; j++) begin
         beat.candidate_index  = MAP_ADDR_BITS'(best_slot[j]);
         beat.squared_distance = DIST_BITS'(best_dist[j]);
         beat.short_list       = (n < K_MAX);
         beat.last_result      = (j == found - 1);
         pending_candidates = {pending_candidates, beat};
      end
   endfunction

   // Compare one result beat with the oldest expectation
   task automatic check_beat(input rsp_beat_type got);
      rsp_beat_type want;
      if (pending_candidates.size() == 0) begin
         $error("unexpected result beat: index %0d distance %0d",
                got.candidate_index, got.squared_distance);
         error_count++;
      end else begin
         want = pending_candidates.pop_front();
         beats_checked++;
         if (got.candidate_index !== want.candidate_index) begin
            $error("candidate_index: expected %0d, got %0d",
                   want.candidate_index, got.candidate_index);
            error_count++;
         end
         if (got.squared_distance !== want.squared_distance) begin
            $error("squared_distance: expected %0d, got %0d",
                   want.squared_distance, got.squared_distance);
            error_count++;
         end
         if (got.short_list !== want.short_list) begin
            $error("short_list: expected %0b, got %0b", want.short_list, got.short_list);
            error_count++;
         end
         if (got.last_result !== want.last_result) begin
            $error("last_result: expected %0b, got %0b", want.last_result, got.last_result);
            error_count++;
         end
      end
   endtask

   // Check each accepted result beat, then pick the next ready level
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         check_beat(rsp_data);
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Send one request beat, hold it until accepted, then update the predictor
   task automatic send_beat(input logic kind, input int slot,
                            input logic signed [COORD_BITS-1:0] x,
                            input logic signed [COORD_BITS-1:0] y);
      req_beat_type beat;
      beat.req_type    = kind;
      beat.point_index = MAP_ADDR_BITS'(slot);
      beat.point_x     = x;
      beat.point_y     = y;
      while ($urandom_range(0, 99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do
         @(posedge clock);
      while (!req_ready);
      items_sent++;
      if (kind == REQ_LOAD) begin
         map_x[beat.point_index]       = x;
         map_y[beat.point_index]       = y;
         slot_loaded[beat.point_index] = 1'b1;
      end else begin
         queries_sent++;
         rank_nearest(x, y);
      end
   endtask

   // Drop valid and wait until every expected beat has arrived and the block is quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_candidates.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the map size register, then read it back
   task automatic write_map_size(input int value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= MAP_SIZE_ADDR;
      csr_pwdata  <= CSR_DATA_BITS'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      map_size_reg = value & ((1 << CFG_BITS) - 1);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      if (csr_prdata !== CSR_DATA_BITS'(map_size_reg)) begin
         $error("points_in_use: expected %0d, got %0d", map_size_reg, csr_prdata);
         error_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Extremes, tight clusters for equal distances, and wide random values
   function automatic logic signed [COORD_BITS-1:0] random_coord();
      case ($urandom_range(0, 9))
         0:       return COORD_MIN;
         1:       return COORD_MAX;
         2, 3, 4, 5: return COORD_BITS'($signed($urandom_range(0, 8)) - 4);
         6, 7:    return COORD_BITS'($signed($urandom_range(0, 2000)) - 1000);
         default: return COORD_BITS'($urandom());
      endcase
   endfunction

   // A query on an empty map gives no beats
   task automatic test_empty_map();
      send_beat(REQ_QUERY, 0, 16, -16);
      settle();
   endtask

   // Corners of the coordinate range, including the largest possible distance
   task automatic test_extreme_coords();
      write_map_size(4);
      send_beat(REQ_LOAD, 0, COORD_MIN, COORD_MIN);
      send_beat(REQ_LOAD, 1, COORD_MAX, COORD_MAX);
      send_beat(REQ_LOAD, 2, 0, 0);
      send_beat(REQ_LOAD, 3, COORD_MIN, COORD_MAX);
      send_beat(REQ_LOAD, MAP_DEPTH - 1, COORD_MAX, COORD_MIN);
      send_beat(REQ_QUERY, 0, COORD_MAX, COORD_MAX);
      send_beat(REQ_QUERY, 0, COORD_MIN, COORD_MIN);
      settle();
   endtask

   // Duplicate and symmetric points so equal distances must order by slot
   task automatic test_equal_distances();
      write_map_size(6);
      send_beat(REQ_LOAD, 0, 256, 0);
      send_beat(REQ_LOAD, 1, 0, 256);
      send_beat(REQ_LOAD, 2, -256, 0);
      send_beat(REQ_LOAD, 3, 0, -256);
      send_beat(REQ_LOAD, 4, 256, 0);
      send_beat(REQ_LOAD, 5, 512, 512);
      send_beat(REQ_QUERY, 0, 0, 0);
      send_beat(REQ_QUERY, 0, 256, 0);
      settle();
   endtask

   // Phases of random map size: fill the searched slots, then mix loads and queries
   task automatic test_random_traffic(input int gap_pct, input int stall_pct);
      int target;
      int n;
      int n_eff;
      int slot;
      req_gap_pct   = gap_pct;
      rsp_stall_pct = stall_pct;
      target = items_sent + RANDOM_BEATS_PER_MODE;
      while (items_sent < target) begin
         case ($urandom_range(0, 19))
            0:                      n = 0;
            1, 2, 3, 4, 5, 6, 7, 8, 9, 10: n = $urandom_range(1, 16);
            11, 12, 13, 14, 15:     n = $urandom_range(K_MAX - 2, K_MAX + 2);
            default:                n = $urandom_range(17, 2 * K_MAX);
         endcase
         n_eff = n;
         settle();
         write_map_size(n);
         for (int i = 0; i < n_eff; i++)
            if (!slot_loaded[i])
               send_beat(REQ_LOAD, i, random_coord(), random_coord());
         repeat ($urandom_range(6, 16)) begin
            if (items_sent >= target)
               break;
            if ($urandom_range(0, 99) < 45) begin
               send_beat(REQ_QUERY, $urandom_range(0, MAP_DEPTH - 1),
                         random_coord(), random_coord());
            end else begin
               if (n_eff == 0 || $urandom_range(0, 9) == 0)
                  slot = $urandom_range(0, MAP_DEPTH - 1);
               else
                  slot = $urandom_range(0, n_eff - 1);
               send_beat(REQ_LOAD, slot, random_coord(), random_coord());
            end
         end
      end
      settle();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      req_gap_pct   = 19;
      rsp_stall_pct = 82;
      test_empty_map();
      test_extreme_coords();
      test_equal_distances();
      test_random_traffic(19, 82);
      test_random_traffic(82, 19);
      test_random_traffic(0, 0);
      $display("Sent %0d request beats (%0d queries), checked %0d result beats.",
               items_sent, queries_sent, beats_checked);
      $display("Covered empty, short and full lists, ties and coordinate corners.");
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // Hard stop if the block hangs
   initial begin
      #20_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
